### rtl/fost_pkg.sv
package fost_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int OCC_W   = $clog2(ENTRIES + 1);

    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [OCC_W-1:0] t_occ;

    typedef enum logic [1:0] {
        KIND_ACK   = 2'd0,
        KIND_ENTRY = 2'd1,
        KIND_EMPTY = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_INC   = 2'd0,
        ST_ADDED = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [63:0] key_low;
        logic [15:0] key_high;
        logic [31:0] count;
    } t_entry;

    typedef struct packed {
        logic   we;
        t_idx   waddr;
        t_entry wdata;
        logic   re;
        t_idx   raddr;
    } t_mem_req;

    typedef struct packed {
        t_kind       kind;
        t_status     status;
        logic [3:0]  position;
        logic [31:0] count_value;
        logic [63:0] entry_low;
        logic [15:0] entry_high;
        logic        last;
    } t_result;

    function automatic logic [3:0] to_pos(input t_idx i);
        logic [IDX_W+3:0] wide;
        wide = {4'b0000, i};
        return wide[3:0];
    endfunction

endpackage

### rtl/fost_if.sv
interface fost_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [63:0] symbol_low;
    logic [15:0] symbol_high;

    modport source(output valid, action, symbol_low, symbol_high, input ready);
    modport sink(input valid, action, symbol_low, symbol_high, output ready);
endinterface

interface fost_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [3:0]  position;
    logic [31:0] count_value;
    logic [63:0] entry_low;
    logic [15:0] entry_high;
    logic        last;

    modport source(output valid, kind, status, position, count_value, entry_low,
                   entry_high, last, input ready);
    modport sink(input valid, kind, status, position, count_value, entry_low,
                 entry_high, last, output ready);
endinterface

### rtl/frequency_ordered_symbol_table_unit.sv
// Channel  Dir  Modport             Payload
// i_in     in   fost_in_if.sink     action, symbol_low, symbol_high
// o_out    out  fost_out_if.source  kind, status, position, count_value, entry_low,
//                                   entry_high, last
//
// Insert: accept, search the entries in order through the single read port
// (registered read data), move each entry with a smaller count forward, then
// place and result; a saturated count or a full table goes straight to result.
// Read-out: one cycle per entry at the memory read port while o_out drains.
// Synchronous active-low reset empties the table at once; no clearing pass.
// A stall on o_out holds the block; a new item is taken while a result waits.
module frequency_ordered_symbol_table_unit
    import fost_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    fost_in_if.sink           i_in,
    fost_out_if.source        o_out
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SEARCH = 6'b000010,
        S_BUBBLE = 6'b000100,
        S_PLACE  = 6'b001000,
        S_RESP   = 6'b010000,
        S_LIST   = 6'b100000
    } t_state;

    t_state      r_state, n_state;
    t_occ        r_occ, n_occ;
    t_occ        r_idx, n_idx;
    logic        r_pend, n_pend;
    t_idx        r_ptag, n_ptag;
    t_idx        r_j, n_j;
    logic [31:0] r_cnt, n_cnt;
    t_status     r_stat, n_stat;
    logic [63:0] r_key_lo, n_key_lo;
    logic [15:0] r_key_hi, n_key_hi;
    t_result     r_res, n_res;
    t_result     r_out, n_out;
    logic        r_ovalid, n_ovalid;

    t_mem_req    mem_req;
    t_entry      rdata;
    logic        in_acc;
    logic        out_free;
    logic        hit;
    logic        tag_last;

    fost_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (rdata)
    );

    assign in_acc   = i_in.valid && (r_state == S_IDLE);
    assign out_free = !r_ovalid || o_out.ready;
    assign hit      = (rdata.key_low == r_key_lo) && (rdata.key_high == r_key_hi);
    assign tag_last = (OCC_W'(r_ptag) + OCC_W'(1)) == r_occ;

    always_comb begin
        n_state  = r_state;
        n_occ    = r_occ;
        n_idx    = r_idx;
        n_pend   = r_pend;
        n_ptag   = r_ptag;
        n_j      = r_j;
        n_cnt    = r_cnt;
        n_stat   = r_stat;
        n_key_lo = r_key_lo;
        n_key_hi = r_key_hi;
        n_res    = r_res;
        n_out    = r_out;
        n_ovalid = r_ovalid;
        mem_req  = '0;

        if (o_out.ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_key_lo = i_in.symbol_low;
                    n_key_hi = i_in.symbol_high;
                    if (!i_in.action) begin
                        if (r_occ == '0) begin
                            n_cnt   = 32'd1;
                            n_j     = '0;
                            n_occ   = OCC_W'(1);
                            n_stat  = ST_ADDED;
                            n_state = S_PLACE;
                        end else begin
                            n_idx   = '0;
                            n_pend  = 1'b0;
                            n_state = S_SEARCH;
                        end
                    end else if (r_occ == '0) begin
                        n_res   = '{kind: KIND_EMPTY, status: ST_INC, position: 4'd0,
                                    count_value: 32'd0, entry_low: 64'd0,
                                    entry_high: 16'd0, last: 1'b1};
                        n_state = S_RESP;
                    end else begin
                        mem_req.re    = 1'b1;
                        mem_req.raddr = '0;
                        n_ptag        = '0;
                        n_state       = S_LIST;
                    end
                end
            end

            S_SEARCH: begin
                if (r_idx < r_occ) begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = r_idx[IDX_W-1:0];
                    n_idx         = r_idx + OCC_W'(1);
                    n_pend        = 1'b1;
                    n_ptag        = r_idx[IDX_W-1:0];
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    if (hit) begin
                        n_pend = 1'b0;
                        if (rdata.count == COUNT_MAX) begin
                            n_res   = '{kind: KIND_ACK, status: ST_INC,
                                        position: to_pos(r_ptag), count_value: COUNT_MAX,
                                        entry_low: r_key_lo, entry_high: r_key_hi,
                                        last: 1'b1};
                            n_state = S_RESP;
                        end else begin
                            n_cnt  = rdata.count + 32'd1;
                            n_j    = r_ptag;
                            n_stat = ST_INC;
                            if (r_ptag == '0) begin
                                n_state = S_PLACE;
                            end else begin
                                mem_req.re    = 1'b1;
                                mem_req.raddr = r_ptag - IDX_W'(1);
                                n_state       = S_BUBBLE;
                            end
                        end
                    end else if (tag_last) begin
                        n_pend = 1'b0;
                        if (r_occ < OCC_W'(ENTRIES)) begin
                            n_cnt   = 32'd1;
                            n_j     = r_occ[IDX_W-1:0];
                            n_occ   = r_occ + OCC_W'(1);
                            n_stat  = ST_ADDED;
                            n_state = S_PLACE;
                        end else begin
                            n_res   = '{kind: KIND_ACK, status: ST_FULL, position: 4'd0,
                                        count_value: 32'd0, entry_low: r_key_lo,
                                        entry_high: r_key_hi, last: 1'b1};
                            n_state = S_RESP;
                        end
                    end
                end
            end

            S_BUBBLE: begin
                if (rdata.count < r_cnt) begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = r_j;
                    mem_req.wdata = rdata;
                    n_j           = r_j - IDX_W'(1);
                    if (r_j != IDX_W'(1)) begin
                        mem_req.re    = 1'b1;
                        mem_req.raddr = r_j - IDX_W'(2);
                    end else begin
                        n_state = S_PLACE;
                    end
                end else begin
                    n_state = S_PLACE;
                end
            end

            S_PLACE: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = r_j;
                mem_req.wdata = '{key_low: r_key_lo, key_high: r_key_hi, count: r_cnt};
                n_res         = '{kind: KIND_ACK, status: r_stat, position: to_pos(r_j),
                                  count_value: r_cnt, entry_low: r_key_lo,
                                  entry_high: r_key_hi, last: 1'b1};
                n_state       = S_RESP;
            end

            S_RESP: begin
                if (out_free) begin
                    n_out    = r_res;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            S_LIST: begin
                if (out_free) begin
                    n_out    = '{kind: KIND_ENTRY, status: ST_INC, position: to_pos(r_ptag),
                                 count_value: rdata.count, entry_low: rdata.key_low,
                                 entry_high: rdata.key_high, last: tag_last};
                    n_ovalid = 1'b1;
                    if (tag_last) begin
                        n_state = S_IDLE;
                    end else begin
                        mem_req.re    = 1'b1;
                        mem_req.raddr = r_ptag + IDX_W'(1);
                        n_ptag        = r_ptag + IDX_W'(1);
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_occ    <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_occ    <= n_occ;
            r_pend   <= n_pend;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_ptag   <= n_ptag;
        r_j      <= n_j;
        r_cnt    <= n_cnt;
        r_stat   <= n_stat;
        r_key_lo <= n_key_lo;
        r_key_hi <= n_key_hi;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_ovalid;
    assign o_out.kind        = r_out.kind;
    assign o_out.status      = r_out.status;
    assign o_out.position    = r_out.position;
    assign o_out.count_value = r_out.count_value;
    assign o_out.entry_low   = r_out.entry_low;
    assign o_out.entry_high  = r_out.entry_high;
    assign o_out.last        = r_out.last;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCC_W'(ENTRIES))
        else $error("occupancy above table depth");

    a_occ_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_occ == $past(r_occ) || r_occ == $past(r_occ) + OCC_W'(1)))
        else $error("occupancy moved by more than one");

    a_bubble_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BUBBLE) |-> (r_j != '0))
        else $error("bubble step at head of table");

    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_LIST || r_state == S_RESP) |-> !mem_req.we)
        else $error("table write outside insert");

endmodule

### rtl/fost_mem.sv
module fost_mem
    import fost_pkg::*;
(
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_entry   o_rdata
);

    t_entry r_mem [ENTRIES];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
